[hdl/assert_macros.svh]
// Assertion macros for the escape-time fractal pixel block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ETFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ETFP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[hdl/etfp_pkg.sv]
// Shared types, constants and helpers for the escape-time fractal pixel block.
// No dependencies.
`default_nettype none

package etfp_pkg;

  localparam int PIX_W        = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int Q_W          = 48;   // Q22.26 working word
  localparam int FRAC_W       = 26;
  localparam int HALF_W       = 24;   // split point of the partial products
  localparam int FRAC_SHIFT   = 2;    // Q4.28 to Q22.26
  localparam int MAX_ITER_DEF = 150;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_W      = 9;
  localparam int COLOR_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_RE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM = 3'd6;

  localparam logic [COLOR_W-1:0] COL_R = 8'd17;
  localparam logic [COLOR_W-1:0] COL_G = 8'd3;
  localparam logic [COLOR_W-1:0] COL_B = 8'd13;

  localparam logic signed [Q_W-1:0] LIM_Q = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W:0] ESC_THRESH = (Q_W+1)'(64'd1000000 << FRAC_W);

  typedef struct packed {
    logic                         fractal_mode;
    logic signed [CFG_DATA_W-1:0] left_re;
    logic signed [CFG_DATA_W-1:0] top_im;
    logic signed [CFG_DATA_W-1:0] step_re;
    logic signed [CFG_DATA_W-1:0] step_im;
    logic signed [CFG_DATA_W-1:0] julia_re;
    logic signed [CFG_DATA_W-1:0] julia_im;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fractal_mode: 1'b1,
    left_re:      -32'sd536870912,
    top_im:       32'sd536870912,
    step_re:      32'sd1048576,
    step_im:      32'sd1048576,
    julia_re:     -32'sd80530637,
    julia_im:     -32'sd268435456
  };

  // Start of one orbit: initial z and the added constant c.
  typedef struct packed {
    logic signed [Q_W-1:0] zr;
    logic signed [Q_W-1:0] zi;
    logic signed [Q_W-1:0] cr;
    logic signed [Q_W-1:0] ci;
  } point_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_st_t;

  // Clamp symmetrically to +-(2^47 - 1).
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W+1:0] v);
    logic signed [Q_W+1:0] hi;
    hi = (Q_W+2)'(LIM_Q);
    if (v > hi) begin
      return LIM_Q;
    end else if (v < -hi) begin
      return -LIM_Q;
    end
    return v[Q_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/etfp_if.sv]
// Channel interfaces: pixel input, result output and configuration write.
// Depends on etfp_pkg.
`default_nettype none

interface etfp_pixel_if;
  import etfp_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] column;
  logic [PIX_W-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface etfp_result_if;
  import etfp_pkg::*;
  logic               valid;
  logic               ready;
  logic               escaped;
  logic [COUNT_W-1:0] escape_count;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  modport source (output valid, escaped, escape_count, red, green, blue, input ready);
  modport sink   (input valid, escaped, escape_count, red, green, blue, output ready);
endinterface

interface etfp_cfg_if;
  import etfp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/etfp_front.sv]
// Front end: accepts pixels, maps them to complex points, picks z0 and c.
// Depends on etfp_pkg and etfp_if.
`default_nettype none

module etfp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  etfp_pixel_if.sink              pix_i,
  input  wire etfp_pkg::cfg_t     cfg_i,
  output      logic               push_valid_o,
  output      etfp_pkg::point_t   push_data_o,
  input  wire etfp_pkg::queue_st_t q_st_i
);
  import etfp_pkg::*;

  localparam int PROD_W = PIX_W + 1 + CFG_DATA_W;

  logic                    s1_v_q, s2_v_q;
  logic                    s1_adv, s2_adv;
  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic signed [PROD_W:0]   pre, pim;
  logic signed [Q_W-1:0]    pre_q26, pim_q26, jre_q26, jim_q26;
  point_t                   pt_d, pt_q;

  assign s2_adv      = !s2_v_q || !q_st_i.full;
  assign s1_adv      = !s1_v_q || s2_adv;
  assign pix_i.ready = s1_adv;

  // Form the point in Q4.28, then drop two fraction bits (floor).
  always_comb begin
    pre     = (PROD_W+1)'(cfg_i.left_re) + (PROD_W+1)'(prod_re_q);
    pim     = (PROD_W+1)'(cfg_i.top_im) - (PROD_W+1)'(prod_im_q);
    pre_q26 = Q_W'(pre >>> FRAC_SHIFT);
    pim_q26 = Q_W'(pim >>> FRAC_SHIFT);
    jre_q26 = Q_W'(cfg_i.julia_re >>> FRAC_SHIFT);
    jim_q26 = Q_W'(cfg_i.julia_im >>> FRAC_SHIFT);
    if (cfg_i.fractal_mode) begin
      pt_d = '{zr: '0, zi: '0, cr: pre_q26, ci: pim_q26};
    end else begin
      pt_d = '{zr: pre_q26, zi: pim_q26, cr: jre_q26, ci: jim_q26};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= pix_i.valid;
      end
      if (s2_adv) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && pix_i.valid) begin
      prod_re_q <= $signed({1'b0, pix_i.column}) * cfg_i.step_re;
      prod_im_q <= $signed({1'b0, pix_i.row}) * cfg_i.step_im;
    end
    if (s2_adv && s1_v_q) begin
      pt_q <= pt_d;
    end
  end

  assign push_valid_o = s2_v_q;
  assign push_data_o  = pt_q;

endmodule

`default_nettype wire

[hdl/etfp_queue.sv]
// Short queue of orbit start points between front end and iteration core.
// Depends on etfp_pkg.
`default_nettype none

module etfp_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire etfp_pkg::point_t    push_data_i,
  input  wire logic                pop_i,
  output      etfp_pkg::point_t    pop_data_o,
  output      etfp_pkg::queue_st_t st_o
);
  import etfp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  point_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign st_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign st_o.count = cnt_q;
  assign do_push    = push_i && !st_o.full;
  assign do_pop     = pop_i && !st_o.empty;
  assign pop_data_o = mem_q[rd_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/etfp_mul.sv]
// Two-stage Q22.26 multiplier: truncates toward zero, clamps to +-(2^47 - 1).
// Depends on etfp_pkg.
`default_nettype none

module etfp_mul (
  input  wire logic                         clk_i,
  input  wire logic signed [etfp_pkg::Q_W-1:0] a_i,
  input  wire logic signed [etfp_pkg::Q_W-1:0] b_i,
  output      logic signed [etfp_pkg::Q_W-1:0] p_o
);
  import etfp_pkg::*;

  localparam int AH_W     = Q_W - 1 - HALF_W;
  localparam int HH_W     = 2 * AH_W;
  localparam int HH_SHIFT = 2 * HALF_W - FRAC_W;
  localparam int HH_LIM_W = Q_W - 1 - HH_SHIFT;
  localparam int T_SHIFT  = FRAC_W - HALF_W;
  localparam int X_W      = AH_W + HALF_W;
  localparam int T_W      = X_W + 2;

  logic [Q_W-1:0]    ua, ub;
  logic [AH_W-1:0]   ah, bh;
  logic [HALF_W-1:0] al, bl;
  logic [2*HALF_W-1:0] albl;
  logic [HH_W-1:0]   hh_q;
  logic [X_W-1:0]    ahbl_q, albh_q;
  logic [HALF_W-1:0] albl_q;
  logic              neg_q;
  logic [T_W-1:0]    t;
  logic [Q_W-1:0]    m;
  logic [Q_W-2:0]    mag;
  logic              hh_over;

  // Stage one: magnitudes and partial products.
  always_comb begin
    ua   = a_i[Q_W-1] ? $unsigned(-a_i) : $unsigned(a_i);
    ub   = b_i[Q_W-1] ? $unsigned(-b_i) : $unsigned(b_i);
    ah   = ua[Q_W-2:HALF_W];
    al   = ua[HALF_W-1:0];
    bh   = ub[Q_W-2:HALF_W];
    bl   = ub[HALF_W-1:0];
    albl = al * bl;
  end

  always_ff @(posedge clk_i) begin
    hh_q   <= ah * bh;
    ahbl_q <= ah * bl;
    albh_q <= al * bh;
    albl_q <= albl[2*HALF_W-1:HALF_W];
    neg_q  <= a_i[Q_W-1] ^ b_i[Q_W-1];
  end

  // Stage two: sum the partials, clamp, restore the sign.
  always_comb begin
    hh_over = |hh_q[HH_W-1:HH_LIM_W];
    t       = T_W'(albl_q) + T_W'(ahbl_q) + T_W'(albh_q);
    m       = Q_W'({hh_q[HH_LIM_W-1:0], {HH_SHIFT{1'b0}}}) + Q_W'(t[T_W-1:T_SHIFT]);
    mag     = (hh_over || m[Q_W-1]) ? {(Q_W-1){1'b1}} : m[Q_W-2:0];
  end

  always_ff @(posedge clk_i) begin
    p_o <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

`default_nettype wire

[hdl/etfp_core.sv]
// Iteration core: runs z = z^2 + c on three multipliers, holds the result.
// Depends on etfp_pkg, etfp_if and etfp_mul.
`default_nettype none

module etfp_core #(
  parameter int MAX_ITER = etfp_pkg::MAX_ITER_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire etfp_pkg::point_t    pop_data_i,
  input  wire etfp_pkg::queue_st_t q_st_i,
  output      logic                pop_o,
  etfp_result_if.source            res_o
);
  import etfp_pkg::*;

  localparam int IT_W = $clog2(MAX_ITER + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [IT_W-1:0]       it_q, it_d;
  logic                  esc_q, esc_d;
  logic                  load, step, res_load;
  logic                  res_v_q;
  logic signed [Q_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [Q_W-1:0] rr, ii, ri, zr_n, zi_n, im_dbl_sat;
  logic signed [Q_W+1:0] re_sum, im_dbl, im_sum;
  logic [Q_W:0]          mag_sum;
  logic                  esc_now, last_iter;
  logic [IT_W:0]         k;
  logic [COLOR_W-1:0]    k8;

  etfp_mul u_mul_rr (.clk_i, .a_i(zr_q), .b_i(zr_q), .p_o(rr));
  etfp_mul u_mul_ii (.clk_i, .a_i(zi_q), .b_i(zi_q), .p_o(ii));
  etfp_mul u_mul_ri (.clk_i, .a_i(zr_q), .b_i(zi_q), .p_o(ri));

  // The squares of z also give the escape test for the z they came from.
  always_comb begin
    mag_sum    = {1'b0, $unsigned(rr)} + {1'b0, $unsigned(ii)};
    esc_now    = (it_q != '0) && (mag_sum > ESC_THRESH);
    last_iter  = (it_q == IT_W'(MAX_ITER));
    re_sum     = (Q_W+2)'(rr) - (Q_W+2)'(ii) + (Q_W+2)'(cr_q);
    zr_n       = sat_q(re_sum);
    im_dbl     = (Q_W+2)'(ri) <<< 1;
    im_dbl_sat = sat_q(im_dbl);
    im_sum     = (Q_W+2)'(im_dbl_sat) + (Q_W+2)'(ci_q);
    zi_n       = sat_q(im_sum);
    k          = {it_q, 1'b0};
    k8         = COLOR_W'(k);
  end

  always_comb begin
    state_d  = state_q;
    it_d     = it_q;
    esc_d    = esc_q;
    load     = 1'b0;
    step     = 1'b0;
    res_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_st_i.empty) begin
          load    = 1'b1;
          it_d    = '0;
          esc_d   = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_COMB;
      S_COMB: state_d = S_UPD;
      S_UPD: begin
        if (esc_now) begin
          esc_d   = 1'b1;
          state_d = S_DONE;
        end else if (last_iter) begin
          state_d = S_DONE;
        end else begin
          step    = 1'b1;
          it_d    = it_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (!res_v_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      it_q    <= '0;
      esc_q   <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
      esc_q   <= esc_d;
      if (res_load) begin
        res_v_q <= 1'b1;
      end else if (res_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      zr_q <= pop_data_i.zr;
      zi_q <= pop_data_i.zi;
      cr_q <= pop_data_i.cr;
      ci_q <= pop_data_i.ci;
    end else if (step) begin
      zr_q <= zr_n;
      zi_q <= zi_n;
    end
    if (res_load) begin
      res_o.escaped      <= esc_q;
      res_o.escape_count <= esc_q ? COUNT_W'(k) : '0;
      res_o.red          <= esc_q ? COLOR_W'(k8 * COL_R) : '0;
      res_o.green        <= esc_q ? COLOR_W'(k8 * COL_G) : '0;
      res_o.blue         <= esc_q ? COLOR_W'(k8 * COL_B) : '0;
    end
  end

  assign res_o.valid = res_v_q;

endmodule

`default_nettype wire

[hdl/escape_time_fractal_pixel.sv]
// Escape-time fractal pixel (Mandelbrot / Julia), Q22.26 fixed point.
// Path: front-end product and point registers, the start-point queue, the
//   multiply/combine/update loop until escape or MAX_ITER (black pixel), then the result register.
// Pixel rate is set by the multiply/sum/update loop around the z registers; the front
//   end and queue keep taking pixels while an orbit runs, until the queue is full.
// Reset: asynchronous, active low; empties the pipeline and loads the default view.
`default_nettype none
`include "assert_macros.svh"

module escape_time_fractal_pixel #(
  parameter int MAX_ITER = etfp_pkg::MAX_ITER_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  etfp_pixel_if.sink    pix_i,
  etfp_result_if.source res_o,
  etfp_cfg_if.sink      cfg_i
);
  import etfp_pkg::*;

  cfg_t      cfg_q;
  logic      push_valid, pop;
  point_t    push_data, pop_data;
  queue_st_t q_st;

  // Config register file: always ready, writes land on the next edge.
  // Writes to an index past the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MODE:     cfg_q.fractal_mode <= cfg_i.data[0];
        REG_LEFT_RE:  cfg_q.left_re      <= $signed(cfg_i.data);
        REG_TOP_IM:   cfg_q.top_im       <= $signed(cfg_i.data);
        REG_STEP_RE:  cfg_q.step_re      <= $signed(cfg_i.data);
        REG_STEP_IM:  cfg_q.step_im      <= $signed(cfg_i.data);
        REG_JULIA_RE: cfg_q.julia_re     <= $signed(cfg_i.data);
        REG_JULIA_IM: cfg_q.julia_im     <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Front end: map pixel to point and choose z0 / c from the mode.
  etfp_front u_front (
    .clk_i,
    .rst_ni,
    .pix_i,
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .q_st_i       (q_st)
  );

  // Decouple the front end from the long-running iteration.
  etfp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push_valid),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .st_o        (q_st)
  );

  // Back end: iterate the orbit and hold the finished pixel in the output register.
  etfp_core #(.MAX_ITER(MAX_ITER)) u_core (
    .clk_i,
    .rst_ni,
    .pop_data_i (pop_data),
    .q_st_i     (q_st),
    .pop_o      (pop),
    .res_o
  );

  // Queue occupancy never passes its depth.
  `ETFP_ASSERT_NEVER(a_queue_over, q_st.count > QCNT_W'(QUEUE_DEPTH), "queue overflow")
  // A black pixel carries no count and no colour.
  `ETFP_ASSERT(a_black_zero, res_o.valid && !res_o.escaped |-> res_o.escape_count == '0 && res_o.red == '0 && res_o.green == '0 && res_o.blue == '0, "black pixel not zero")
  // Escape counts are even and red follows from the count.
  `ETFP_ASSERT(a_count_color, res_o.valid && res_o.escaped |-> !res_o.escape_count[0] && res_o.red == COLOR_W'(res_o.escape_count[7:0] * COL_R), "count and colour disagree")

endmodule

`default_nettype wire
